// File: rtl/q2e_pkg.sv
// Shared types, widths and constants for the quaternion to ZYX Euler converter.
// Used by every module of the block; no dependencies.
package q2e_pkg;

    localparam int PW       = 32;   // Q2.28 product
    localparam int VW       = 34;   // doubled sums
    localparam int SW       = 30;   // clamped sinp
    localparam int CW       = 40;   // CORDIC x/y lanes
    localparam int AW       = 25;   // CORDIC angle, 1/256 centidegree
    localparam int RW       = 58;   // square root datapath
    localparam int SQ_STEPS = 29;   // root bits
    localparam int LANES    = 3;

    localparam int LANE_PITCH = 0;
    localparam int LANE_ROLL  = 1;
    localparam int LANE_YAW   = 2;

    localparam logic signed [VW-1:0] ONE_Q28  = VW'(1) <<< 28;
    localparam logic signed [VW-1:0] NONE_Q28 = -(VW'(1) <<< 28);
    localparam logic [56:0]          ONE_Q56  = 57'(1) << 56;
    localparam logic [42:0]          LOCK_TH  = 43'(9999) * (43'(1) << 28);
    localparam logic signed [AW-1:0] HALF_TURN = 25'sd4608000;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [AW-1:0] angle_t;

    typedef struct packed {
        logic signed [SW-1:0] sinp;
        logic signed [VW-1:0] roll_y;
        logic signed [VW-1:0] roll_x;
        logic signed [VW-1:0] yaw_y;
        logic signed [VW-1:0] yaw_x;
        logic                 lock;
        logic                 pos;
    } side_t;

    function automatic angle_t atan_val(input int i);
        angle_t v;
        case (i)
            0:       v = 25'sd1152000;
            1:       v = 25'sd680065;
            2:       v = 25'sd359328;
            3:       v = 25'sd182400;
            4:       v = 25'sd91554;
            5:       v = 25'sd45822;
            6:       v = 25'sd22916;
            7:       v = 25'sd11459;
            8:       v = 25'sd5730;
            9:       v = 25'sd2865;
            10:      v = 25'sd1432;
            11:      v = 25'sd716;
            12:      v = 25'sd358;
            13:      v = 25'sd179;
            14:      v = 25'sd90;
            15:      v = 25'sd45;
            16:      v = 25'sd22;
            17:      v = 25'sd11;
            18:      v = 25'sd6;
            19:      v = 25'sd3;
            20:      v = 25'sd1;
            21:      v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/q2e_sqrt_cell.sv
// One restoring square-root cell: resolves one root bit per cycle while en is high.
// Carries the side payload to its neighbor. Depends on q2e_pkg.
module q2e_sqrt_cell #(
    parameter int EXP = 0
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [q2e_pkg::RW-1:0] v_in,
    input  logic [q2e_pkg::RW-1:0] r_in,
    input  q2e_pkg::side_t         side_in,
    output logic [q2e_pkg::RW-1:0] v_out,
    output logic [q2e_pkg::RW-1:0] r_out,
    output q2e_pkg::side_t         side_out
);

    localparam logic [q2e_pkg::RW-1:0] BIT_VAL = q2e_pkg::RW'(1) << EXP;

    logic [q2e_pkg::RW-1:0] t;
    logic [q2e_pkg::RW-1:0] v_next;
    logic [q2e_pkg::RW-1:0] r_next;
    logic [q2e_pkg::RW-1:0] v_reg;
    logic [q2e_pkg::RW-1:0] r_reg;
    q2e_pkg::side_t         side_reg;

    always_comb
    begin
        t = r_in + BIT_VAL;
        if (v_in >= t)
        begin
            v_next = v_in - t;
            r_next = (r_in >> 1) + BIT_VAL;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg    <= v_next;
            r_reg    <= r_next;
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign r_out    = r_reg;
    assign side_out = side_reg;

endmodule

// File: rtl/q2e_cordic_pre.sv
// CORDIC entry cell: zero detect and folding of the left half plane.
// Depends on q2e_pkg.
module q2e_cordic_pre (
    input  logic                clk,
    input  logic                en,
    input  q2e_pkg::cval_t      y_in,
    input  q2e_pkg::cval_t      x_in,
    output q2e_pkg::cval_t      x_out,
    output q2e_pkg::cval_t      y_out,
    output q2e_pkg::angle_t     z_out,
    output logic                zf_out
);

    q2e_pkg::cval_t  x_next, y_next, x_reg, y_reg;
    q2e_pkg::angle_t z_next, z_reg;
    logic            zf_next, zf_reg;

    always_comb
    begin
        zf_next = (x_in == '0) && (y_in == '0);
        x_next  = x_in;
        y_next  = y_in;
        z_next  = '0;
        if (x_in < 0)
        begin
            x_next = -x_in;
            y_next = -y_in;
            z_next = (y_in >= 0) ? q2e_pkg::HALF_TURN : -q2e_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            zf_reg <= zf_next;
        end
    end

    assign x_out  = x_reg;
    assign y_out  = y_reg;
    assign z_out  = z_reg;
    assign zf_out = zf_reg;

endmodule

// File: rtl/q2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its output register.
// Depends on q2e_pkg (atan table).
module q2e_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic            clk,
    input  logic            en,
    input  q2e_pkg::cval_t  x_in,
    input  q2e_pkg::cval_t  y_in,
    input  q2e_pkg::angle_t z_in,
    input  logic            zf_in,
    output q2e_pkg::cval_t  x_out,
    output q2e_pkg::cval_t  y_out,
    output q2e_pkg::angle_t z_out,
    output logic            zf_out
);

    localparam q2e_pkg::angle_t ATAN = q2e_pkg::atan_val(SHIFT);

    q2e_pkg::cval_t  dx, dy, x_next, y_next, x_reg, y_reg;
    q2e_pkg::angle_t z_next, z_reg;
    logic            zf_reg;

    always_comb
    begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        if (y_in >= 0)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            zf_reg <= zf_in;
        end
    end

    assign x_out  = x_reg;
    assign y_out  = y_reg;
    assign z_out  = z_reg;
    assign zf_out = zf_reg;

endmodule

// File: rtl/quaternion_to_euler_zyx_top.sv
// Quaternion (Q1.14) to ZYX Euler angles in centidegrees, fully pipelined.
// Uses q2e_pkg, q2e_sqrt_cell, q2e_cordic_pre, q2e_cordic_cell.
//
//  channel | signals                                | direction
//  --------+----------------------------------------+----------
//  in      | in_valid, in_stall, quat_w/x/y/z       | request in
//  out     | out_valid, out_stall, roll/pitch/yaw,  | request out
//          | gimbal_lock                            |
//  cfg     | cfg_wr_en, cfg_wr_data (declination)   | write only
//
// One request per cycle while in_stall is low. The pipeline holds 3 arithmetic stages,
// 29 square-root cells, one CORDIC entry cell, CORDIC_STAGES rotation cells and
// the output register.
// Reset clears valids and declination. A stalled result sits in the output
// register; a second one goes to a skid register, and only then in_stall rises.
module quaternion_to_euler_zyx_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic signed [15:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [16:0] yaw_angle,
    output logic               gimbal_lock
);

    localparam int DEPTH = 3 + q2e_pkg::SQ_STEPS + 1 + CORDIC_STAGES;
    localparam int PW = q2e_pkg::PW;
    localparam int VW = q2e_pkg::VW;
    localparam int SW = q2e_pkg::SW;
    localparam int CW = q2e_pkg::CW;
    localparam int AW = q2e_pkg::AW;
    localparam int RW = q2e_pkg::RW;
    localparam int NQ = q2e_pkg::SQ_STEPS;

    logic en;
    logic [DEPTH-1:0] vld_reg;
    logic signed [15:0] decl_reg;

    // stage 1: products
    logic signed [PW-1:0] p_wy_reg, p_zx_reg, p_wx_reg, p_yz_reg, p_xx_reg;
    logic signed [PW-1:0] p_yy_reg, p_wz_reg, p_xy_reg, p_zz_reg;
    logic signed [15:0]   w1_reg, z1_reg;

    // stage 2: sums
    logic signed [VW-1:0] d_sinp, ry_next, rx_next, yy_next, yx_next;
    logic signed [SW-1:0] sinp_next, sinp2_reg;
    logic signed [VW-1:0] ry2_reg, rx2_reg, yy2_reg, yx2_reg;
    logic signed [15:0]   w2_reg, z2_reg;

    // stage 3: square, lock test
    logic [SW-2:0]        mag;
    logic                 lock_next;
    logic [56:0]          rad_reg;
    q2e_pkg::side_t       side_next, side3_reg;

    logic [RW-1:0]        sq_v [NQ+1];
    logic [RW-1:0]        sq_r [NQ+1];
    q2e_pkg::side_t       sq_s [NQ+1];

    q2e_pkg::cval_t       lane_y [q2e_pkg::LANES];
    q2e_pkg::cval_t       lane_x [q2e_pkg::LANES];
    q2e_pkg::cval_t       cx [q2e_pkg::LANES][CORDIC_STAGES+1];
    q2e_pkg::cval_t       cy [q2e_pkg::LANES][CORDIC_STAGES+1];
    q2e_pkg::angle_t      cz [q2e_pkg::LANES][CORDIC_STAGES+1];
    logic                 czf [q2e_pkg::LANES][CORDIC_STAGES+1];
    logic [1:0]           flag_reg [CORDIC_STAGES+1];

    // output side
    logic signed [AW:0]   a_pitch, a_roll, a_yaw;
    logic signed [17:0]   c_pitch, c_roll, c_yaw;
    logic signed [18:0]   yaw_sum;
    logic signed [15:0]   roll_next;
    logic signed [14:0]   pitch_next;
    logic signed [16:0]   yaw_next;
    logic                 lock_out, pos_out, push, take;
    logic                 out_v_reg, skid_v_reg;
    logic signed [15:0]   roll_reg, skid_roll_reg;
    logic signed [14:0]   pitch_reg, skid_pitch_reg;
    logic signed [16:0]   yaw_reg, skid_yaw_reg;
    logic                 gl_reg, skid_gl_reg;

    function automatic logic signed [17:0] to_centi(input logic signed [AW:0] a);
        logic signed [AW:0] s;
        s = a + (AW+1)'(128);
        return 18'(s >>> 8);
    endfunction

    assign en       = !skid_v_reg;
    assign in_stall = skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                decl_reg <= cfg_wr_data;
            if (en)
                vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wy_reg <= PW'(quat_w) * PW'(quat_y);
            p_zx_reg <= PW'(quat_z) * PW'(quat_x);
            p_wx_reg <= PW'(quat_w) * PW'(quat_x);
            p_yz_reg <= PW'(quat_y) * PW'(quat_z);
            p_xx_reg <= PW'(quat_x) * PW'(quat_x);
            p_yy_reg <= PW'(quat_y) * PW'(quat_y);
            p_wz_reg <= PW'(quat_w) * PW'(quat_z);
            p_xy_reg <= PW'(quat_x) * PW'(quat_y);
            p_zz_reg <= PW'(quat_z) * PW'(quat_z);
            w1_reg   <= quat_w;
            z1_reg   <= quat_z;
        end
    end

    always_comb
    begin
        d_sinp  = (VW'(p_wy_reg) - VW'(p_zx_reg)) <<< 1;
        ry_next = (VW'(p_wx_reg) + VW'(p_yz_reg)) <<< 1;
        rx_next = q2e_pkg::ONE_Q28 - ((VW'(p_xx_reg) + VW'(p_yy_reg)) <<< 1);
        yy_next = (VW'(p_wz_reg) + VW'(p_xy_reg)) <<< 1;
        yx_next = q2e_pkg::ONE_Q28 - ((VW'(p_yy_reg) + VW'(p_zz_reg)) <<< 1);
        if (d_sinp > q2e_pkg::ONE_Q28)
            sinp_next = SW'(q2e_pkg::ONE_Q28);
        else if (d_sinp < q2e_pkg::NONE_Q28)
            sinp_next = SW'(q2e_pkg::NONE_Q28);
        else
            sinp_next = SW'(d_sinp);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sinp2_reg <= sinp_next;
            ry2_reg   <= ry_next;
            rx2_reg   <= rx_next;
            yy2_reg   <= yy_next;
            yx2_reg   <= yx_next;
            w2_reg    <= w1_reg;
            z2_reg    <= z1_reg;
        end
    end

    always_comb
    begin
        mag       = (sinp2_reg < 0) ? (SW-1)'(-sinp2_reg) : (SW-1)'(sinp2_reg);
        lock_next = (43'(mag) * 43'd10000) >= q2e_pkg::LOCK_TH;
        side_next.sinp   = sinp2_reg;
        side_next.roll_y = ry2_reg;
        side_next.roll_x = rx2_reg;
        side_next.yaw_y  = lock_next ? VW'(z2_reg) : yy2_reg;
        side_next.yaw_x  = lock_next ? VW'(w2_reg) : yx2_reg;
        side_next.lock   = lock_next;
        side_next.pos    = sinp2_reg > 0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg   <= q2e_pkg::ONE_Q56 - 57'(57'(mag) * 57'(mag));
            side3_reg <= side_next;
        end
    end

    assign sq_v[0] = RW'(rad_reg);
    assign sq_r[0] = '0;
    assign sq_s[0] = side3_reg;

    for (genvar j = 0; j < NQ; j++)
    begin : g_sqrt
        q2e_sqrt_cell #(.EXP(2 * (NQ - 1 - j))) u_cell (
            .clk      (clk),
            .en       (en),
            .v_in     (sq_v[j]),
            .r_in     (sq_r[j]),
            .side_in  (sq_s[j]),
            .v_out    (sq_v[j+1]),
            .r_out    (sq_r[j+1]),
            .side_out (sq_s[j+1])
        );
    end

    always_comb
    begin
        lane_y[q2e_pkg::LANE_PITCH] = CW'(sq_s[NQ].sinp);
        lane_x[q2e_pkg::LANE_PITCH] = {{(CW-NQ){1'b0}}, sq_r[NQ][NQ-1:0]};
        lane_y[q2e_pkg::LANE_ROLL]  = CW'(sq_s[NQ].roll_y);
        lane_x[q2e_pkg::LANE_ROLL]  = CW'(sq_s[NQ].roll_x);
        lane_y[q2e_pkg::LANE_YAW]   = CW'(sq_s[NQ].yaw_y);
        lane_x[q2e_pkg::LANE_YAW]   = CW'(sq_s[NQ].yaw_x);
    end

    for (genvar l = 0; l < q2e_pkg::LANES; l++)
    begin : g_lane
        q2e_cordic_pre u_pre (
            .clk    (clk),
            .en     (en),
            .y_in   (lane_y[l]),
            .x_in   (lane_x[l]),
            .x_out  (cx[l][0]),
            .y_out  (cy[l][0]),
            .z_out  (cz[l][0]),
            .zf_out (czf[l][0])
        );
        for (genvar k = 0; k < CORDIC_STAGES; k++)
        begin : g_stage
            q2e_cordic_cell #(.SHIFT(k)) u_cell (
                .clk    (clk),
                .en     (en),
                .x_in   (cx[l][k]),
                .y_in   (cy[l][k]),
                .z_in   (cz[l][k]),
                .zf_in  (czf[l][k]),
                .x_out  (cx[l][k+1]),
                .y_out  (cy[l][k+1]),
                .z_out  (cz[l][k+1]),
                .zf_out (czf[l][k+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flag_reg[0] <= {sq_s[NQ].lock, sq_s[NQ].pos};
            for (int k = 1; k <= CORDIC_STAGES; k++)
                flag_reg[k] <= flag_reg[k-1];
        end
    end

    always_comb
    begin
        lock_out = flag_reg[CORDIC_STAGES][1];
        pos_out  = flag_reg[CORDIC_STAGES][0];
        a_pitch  = czf[q2e_pkg::LANE_PITCH][CORDIC_STAGES] ? '0
                 : (AW+1)'(cz[q2e_pkg::LANE_PITCH][CORDIC_STAGES]);
        a_roll   = czf[q2e_pkg::LANE_ROLL][CORDIC_STAGES] ? '0
                 : (AW+1)'(cz[q2e_pkg::LANE_ROLL][CORDIC_STAGES]);
        a_yaw    = czf[q2e_pkg::LANE_YAW][CORDIC_STAGES] ? '0
                 : (AW+1)'(cz[q2e_pkg::LANE_YAW][CORDIC_STAGES]);
        if (lock_out)
            a_yaw = pos_out ? (a_yaw <<< 1) : -(a_yaw <<< 1);
        c_pitch = to_centi(a_pitch);
        c_roll  = to_centi(a_roll);
        c_yaw   = to_centi(a_yaw);

        if (c_pitch > 18'sd9000)
            pitch_next = 15'sd9000;
        else if (c_pitch < -18'sd9000)
            pitch_next = -15'sd9000;
        else
            pitch_next = 15'(c_pitch);

        if (lock_out)
            roll_next = '0;
        else if (c_roll > 18'sd18000)
            roll_next = 16'sd18000;
        else if (c_roll < -18'sd18000)
            roll_next = -16'sd18000;
        else
            roll_next = 16'(c_roll);

        yaw_sum = 19'(c_yaw) + 19'(decl_reg);
        if (yaw_sum > 19'sd54000)
            yaw_next = 17'sd54000;
        else if (yaw_sum < -19'sd54000)
            yaw_next = -17'sd54000;
        else
            yaw_next = 17'(yaw_sum);
    end

    assign push = en && vld_reg[DEPTH-1];
    assign take = out_v_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (take)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_v_reg || take)
                out_v_reg <= 1'b1;
            else
                skid_v_reg <= 1'b1;
        end
        else if (take)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (take)
            begin
                roll_reg  <= skid_roll_reg;
                pitch_reg <= skid_pitch_reg;
                yaw_reg   <= skid_yaw_reg;
                gl_reg    <= skid_gl_reg;
            end
        end
        else if (push)
        begin
            if (!out_v_reg || take)
            begin
                roll_reg  <= roll_next;
                pitch_reg <= pitch_next;
                yaw_reg   <= yaw_next;
                gl_reg    <= lock_out;
            end
            else
            begin
                skid_roll_reg  <= roll_next;
                skid_pitch_reg <= pitch_next;
                skid_yaw_reg   <= yaw_next;
                skid_gl_reg    <= lock_out;
            end
        end
    end

    assign out_valid   = out_v_reg;
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;
    assign gimbal_lock = gl_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid holds a request while output is empty");

    a_lock_roll_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && gl_reg) |-> (roll_reg == 16'sd0))
        else $error("roll nonzero under gimbal lock");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> ((yaw_reg <= 17'sd54000) && (yaw_reg >= -17'sd54000)))
        else $error("yaw out of range");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && out_stall))
        else $error("skid filled while output was free");

endmodule
